FILE: src/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and codes for the XOR-checked frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MinFrameSize = 4;

  // Parser phase
  typedef enum logic [2:0] {
    PH_DEST    = 3'd0,
    PH_SIZE    = 3'd1,
    PH_ID      = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CSUM_ERR = 2'd2,
    KIND_LEN_ERR  = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] dest_address;
    logic [ByteW-1:0] frame_size;
    logic [ByteW-1:0] payload_kind;
    logic             end_of_frame;
  } result_t;

  // Handshake between the input register and the parser core
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_req_t;

endpackage

FILE: src/xcfp_in_reg.sv
// ----------------------------------------------------------------------------
// xcfp_in_reg
// Input register: captures one received byte request and holds it until the
// parser core consumes it.
// ----------------------------------------------------------------------------
module xcfp_in_reg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [xcfp_pkg::ByteW-1:0] rx_byte,
  input  logic                     consume,
  output xcfp_pkg::byte_req_t      req
);

  logic                       valid;
  logic [xcfp_pkg::ByteW-1:0] data;
  logic                       accept;

  // Stall only while a held byte cannot move on
  assign in_stall = valid && !consume;
  assign accept   = in_valid && !in_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  // Byte register
  always_ff @(posedge clk) begin
    if (accept) begin
      data <= rx_byte;
    end
  end

  assign req.valid = valid;
  assign req.data  = data;

endmodule

FILE: src/xcfp_core.sv
// ----------------------------------------------------------------------------
// xcfp_core
// Frame parser state and per-byte step: header capture, payload counting,
// running XOR and the status decision on the id byte or the checksum byte.
// ----------------------------------------------------------------------------
module xcfp_core (
  input  logic                clk,
  input  logic                rst,
  input  xcfp_pkg::byte_req_t req,
  input  logic                out_free,
  output logic                consume,
  output logic                res_valid,
  output xcfp_pkg::result_t   res
);

  localparam logic [xcfp_pkg::ByteW-1:0] MinSize = xcfp_pkg::ByteW'(xcfp_pkg::MinFrameSize);

  xcfp_pkg::phase_t           phase, phase_next;
  logic [xcfp_pkg::ByteW-1:0] dest_reg, dest_reg_next;
  logic [xcfp_pkg::ByteW-1:0] size_reg, size_reg_next;
  logic [xcfp_pkg::ByteW-1:0] kind_reg, kind_reg_next;
  logic [xcfp_pkg::ByteW-1:0] bytes_left, bytes_left_next;
  logic [xcfp_pkg::ByteW-1:0] byte_pos, byte_pos_next;
  logic [xcfp_pkg::ByteW-1:0] running_xor, running_xor_next;
  logic                       has_result;
  logic [xcfp_pkg::ByteW-1:0] b;

  assign b = req.data;

  // A byte that yields a result needs a free output slot
  assign consume   = req.valid && (!has_result || out_free);
  assign res_valid = consume && has_result;

  // Step: next state and result
  always_comb begin
    phase_next       = phase;
    dest_reg_next    = dest_reg;
    size_reg_next    = size_reg;
    kind_reg_next    = kind_reg;
    bytes_left_next  = bytes_left;
    byte_pos_next    = byte_pos;
    running_xor_next = running_xor;
    has_result       = 1'b0;
    res.kind          = xcfp_pkg::KIND_PAYLOAD;
    res.payload_byte  = '0;
    res.payload_index = '0;
    res.dest_address  = dest_reg;
    res.frame_size    = size_reg;
    res.payload_kind  = kind_reg;
    res.end_of_frame  = 1'b0;
    unique case (phase)
      xcfp_pkg::PH_SIZE: begin
        size_reg_next    = b;
        running_xor_next = running_xor ^ b;
        phase_next       = xcfp_pkg::PH_ID;
      end
      xcfp_pkg::PH_ID: begin
        kind_reg_next    = b;
        running_xor_next = running_xor ^ b;
        if (size_reg < MinSize) begin
          // Short frame: flag and resync on the next byte
          has_result       = 1'b1;
          res.kind         = xcfp_pkg::KIND_LEN_ERR;
          res.payload_kind = b;
          res.end_of_frame = 1'b1;
          phase_next       = xcfp_pkg::PH_DEST;
        end else begin
          bytes_left_next = size_reg - MinSize;
          byte_pos_next   = '0;
          phase_next      = (size_reg == MinSize) ? xcfp_pkg::PH_CHECK
                                                  : xcfp_pkg::PH_PAYLOAD;
        end
      end
      xcfp_pkg::PH_PAYLOAD: begin
        has_result        = 1'b1;
        res.payload_byte  = b;
        res.payload_index = byte_pos;
        running_xor_next  = running_xor ^ b;
        byte_pos_next     = byte_pos + 1'b1;
        bytes_left_next   = bytes_left - 1'b1;
        if (bytes_left == {{(xcfp_pkg::ByteW-1){1'b0}}, 1'b1}) begin
          phase_next = xcfp_pkg::PH_CHECK;
        end
      end
      xcfp_pkg::PH_CHECK: begin
        has_result       = 1'b1;
        res.kind         = (running_xor == b) ? xcfp_pkg::KIND_GOOD
                                              : xcfp_pkg::KIND_CSUM_ERR;
        res.end_of_frame = 1'b1;
        phase_next       = xcfp_pkg::PH_DEST;
      end
      default: begin
        // Destination byte opens a new frame
        dest_reg_next    = b;
        size_reg_next    = '0;
        kind_reg_next    = '0;
        bytes_left_next  = '0;
        byte_pos_next    = '0;
        running_xor_next = b;
        phase_next       = xcfp_pkg::PH_SIZE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= xcfp_pkg::PH_DEST;
      dest_reg    <= '0;
      size_reg    <= '0;
      kind_reg    <= '0;
      bytes_left  <= '0;
      byte_pos    <= '0;
      running_xor <= '0;
    end else if (consume) begin
      phase       <= phase_next;
      dest_reg    <= dest_reg_next;
      size_reg    <= size_reg_next;
      kind_reg    <= kind_reg_next;
      bytes_left  <= bytes_left_next;
      byte_pos    <= byte_pos_next;
      running_xor <= running_xor_next;
    end
  end

endmodule

FILE: src/xcfp_out_reg.sv
// ----------------------------------------------------------------------------
// xcfp_out_reg
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module xcfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  xcfp_pkg::result_t res_in,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output xcfp_pkg::result_t res_out
);

  logic              valid;
  xcfp_pkg::result_t data;

  // Slot frees up when empty or being taken this cycle
  assign out_free = !valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_in;
    end
  end

  assign out_valid = valid;
  assign res_out   = data;

endmodule

FILE: src/xor_checked_frame_parser.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// A result travels from the input register through the combinational parser
// step into the result register, which drives the outputs.
// Throughput: one byte per cycle unless a result waits on a stalled output.
// Reset: synchronous; parser returns to expecting a destination byte, both
// registers empty.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [xcfp_pkg::ByteW-1:0] rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 kind,
  output logic [xcfp_pkg::ByteW-1:0] payload_byte,
  output logic [xcfp_pkg::ByteW-1:0] payload_index,
  output logic [xcfp_pkg::ByteW-1:0] dest_address,
  output logic [xcfp_pkg::ByteW-1:0] frame_size,
  output logic [xcfp_pkg::ByteW-1:0] payload_kind,
  output logic                       end_of_frame
);

  xcfp_pkg::byte_req_t req;
  xcfp_pkg::result_t   res, res_q;
  logic                consume;
  logic                res_valid;
  logic                out_free;

  xcfp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .consume  (consume),
    .req      (req)
  );

  xcfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_free  (out_free),
    .consume   (consume),
    .res_valid (res_valid),
    .res       (res)
  );

  xcfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign kind          = res_q.kind;
  assign payload_byte  = res_q.payload_byte;
  assign payload_index = res_q.payload_index;
  assign dest_address  = res_q.dest_address;
  assign frame_size    = res_q.frame_size;
  assign payload_kind  = res_q.payload_kind;
  assign end_of_frame  = res_q.end_of_frame;

  // Stall upstream only while a byte is held in the input register
  a_stall_needs_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req.valid)
    else $error("input stalled with empty input register");

  // Status results close a frame, payload results never do
  a_eof_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_of_frame == (kind != xcfp_pkg::KIND_PAYLOAD)))
    else $error("end_of_frame does not match result kind");

  // Status results carry a zero payload byte and index
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != xcfp_pkg::KIND_PAYLOAD) |->
      (payload_byte == '0 && payload_index == '0))
    else $error("status result carries payload data");

endmodule

FILE: bench/tb_xor_checked_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_xor_checked_frame_parser
// Self-checking bench for the XOR-checked frame parser. A parser model in the
// bench tracks header fields, payload position and running XOR for every
// byte request accepted, and queues the results the block must produce. Each
// result the block hands out is checked against the oldest queued one. Stimulus:
// directed header/size corner cases, then random frames with occasional noise,
// a long output hold-off, and a final stretch with no idling on either side.
// ----------------------------------------------------------------------------
module tb_xor_checked_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RandomItems  = 950;
  localparam int          HoldCycles   = 300;
  localparam int          DrainCycles  = 10;
  localparam int          ReportLimit  = 10;
  localparam longint      TimeoutNs    = 5_000_000;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [xcfp_pkg::ByteW-1:0]           rx_byte = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [1:0]                           kind;
  logic [xcfp_pkg::ByteW-1:0]           payload_byte;
  logic [xcfp_pkg::ByteW-1:0]           payload_index;
  logic [xcfp_pkg::ByteW-1:0]           dest_address;
  logic [xcfp_pkg::ByteW-1:0]           frame_size;
  logic [xcfp_pkg::ByteW-1:0]           payload_kind;
  logic                                 end_of_frame;

  // Parser model state
  xcfp_pkg::phase_t           pr_phase = xcfp_pkg::PH_DEST;
  logic [xcfp_pkg::ByteW-1:0] pr_dest  = '0;
  logic [xcfp_pkg::ByteW-1:0] pr_size  = '0;
  logic [xcfp_pkg::ByteW-1:0] pr_pid   = '0;
  logic [xcfp_pkg::ByteW-1:0] pr_left  = '0;
  logic [xcfp_pkg::ByteW-1:0] pr_pos   = '0;
  logic [xcfp_pkg::ByteW-1:0] pr_sum   = '0;

  xcfp_pkg::result_t reports_due[$];
  int unsigned       mismatches = 0;
  int unsigned       items_sent = 0;
  int unsigned       idle_pct = 0;
  int unsigned       rx_gap = 0;
  logic              hold_go = 1'b0;
  logic              hold_on = 1'b0;

  xor_checked_frame_parser i_dut (.*);

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Build one result with the current header fields
  function automatic xcfp_pkg::result_t parser_result(xcfp_pkg::kind_t k,
                                                      logic [xcfp_pkg::ByteW-1:0] b,
                                                      logic [xcfp_pkg::ByteW-1:0] idx,
                                                      logic eof);
    xcfp_pkg::result_t r;
    r.kind          = k;
    r.payload_byte  = b;
    r.payload_index = idx;
    r.dest_address  = pr_dest;
    r.frame_size    = pr_size;
    r.payload_kind  = pr_pid;
    r.end_of_frame  = eof;
    return r;
  endfunction

  // Advance the parser model by one byte, queue any result it causes
  task automatic parse_byte(input logic [xcfp_pkg::ByteW-1:0] b);
    case (pr_phase)
      xcfp_pkg::PH_SIZE: begin
        pr_size  = b;
        pr_sum   = pr_sum ^ b;
        pr_phase = xcfp_pkg::PH_ID;
      end
      xcfp_pkg::PH_ID: begin
        pr_pid = b;
        pr_sum = pr_sum ^ b;
        if (pr_size < xcfp_pkg::MinFrameSize) begin
          // short size: length error, back to frame start
          reports_due.push_back(parser_result(xcfp_pkg::KIND_LEN_ERR, '0, '0, 1'b1));
          pr_phase = xcfp_pkg::PH_DEST;
        end else begin
          pr_left = 8'(pr_size - xcfp_pkg::MinFrameSize);
          pr_pos  = '0;
          if (pr_left == 0) pr_phase = xcfp_pkg::PH_CHECK;
          else pr_phase = xcfp_pkg::PH_PAYLOAD;
        end
      end
      xcfp_pkg::PH_PAYLOAD: begin
        reports_due.push_back(parser_result(xcfp_pkg::KIND_PAYLOAD, b, pr_pos, 1'b0));
        pr_sum  = pr_sum ^ b;
        pr_pos  = pr_pos + 8'd1;
        pr_left = pr_left - 8'd1;
        if (pr_left == 0) pr_phase = xcfp_pkg::PH_CHECK;
      end
      xcfp_pkg::PH_CHECK: begin
        if (pr_sum == b) begin
          reports_due.push_back(parser_result(xcfp_pkg::KIND_GOOD, '0, '0, 1'b1));
        end else begin
          reports_due.push_back(parser_result(xcfp_pkg::KIND_CSUM_ERR, '0, '0, 1'b1));
        end
        pr_phase = xcfp_pkg::PH_DEST;
      end
      default: begin
        pr_dest  = b;
        pr_size  = '0;
        pr_pid   = '0;
        pr_left  = '0;
        pr_pos   = '0;
        pr_sum   = b;
        pr_phase = xcfp_pkg::PH_SIZE;
      end
    endcase
  endtask

  // Offer one byte request, optionally after a random gap; wait for acceptance
  task automatic send_byte(input logic [xcfp_pkg::ByteW-1:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    parse_byte(b);
    items_sent++;
  endtask

  // Whole frame; fill < 0 gives random payload, bad_sum corrupts the checksum
  task automatic send_frame(input logic [xcfp_pkg::ByteW-1:0] dest,
                            input logic [xcfp_pkg::ByteW-1:0] size,
                            input logic [xcfp_pkg::ByteW-1:0] pid,
                            input int fill, input bit bad_sum);
    logic [xcfp_pkg::ByteW-1:0] sum;
    logic [xcfp_pkg::ByteW-1:0] b;
    int                         n;
    sum = dest ^ size ^ pid;
    send_byte(dest);
    send_byte(size);
    send_byte(pid);
    if (size >= xcfp_pkg::MinFrameSize) begin
      n = size - xcfp_pkg::MinFrameSize;
      repeat (n) begin
        b   = (fill < 0) ? 8'($urandom) : 8'(fill);
        sum = sum ^ b;
        send_byte(b);
      end
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum);
    end
  endtask

  // Feed random bytes until the parser expects a destination byte again
  task automatic resync_parser();
    while (pr_phase != xcfp_pkg::PH_DEST) send_byte(8'($urandom));
  endtask

  // Random frame, mostly short sizes; some have a size below four or a bad checksum
  task automatic send_random_frame();
    logic [xcfp_pkg::ByteW-1:0] size;
    int                         pick;
    pick = $urandom_range(99);
    if (pick < 8) size = 8'($urandom_range(0, 3));
    else if (pick < 11) size = 8'($urandom_range(200, 255));
    else if (pick < 30) size = 8'($urandom_range(17, 60));
    else size = 8'($urandom_range(4, 16));
    send_frame(8'($urandom), size, 8'($urandom), -1, $urandom_range(4) == 0);
  endtask

  // Size four: checksum right after the id byte, good and bad
  task automatic test_short_frames();
    send_frame(8'hFF, 8'd4, 8'hFF, -1, 1'b0);
    send_frame(8'h00, 8'd4, 8'h00, -1, 1'b1);
  endtask

  // Sizes below four end the frame at the id byte
  task automatic test_length_errors();
    send_frame(8'h80, 8'd0, 8'h7F, -1, 1'b0);
    send_frame(8'h01, 8'd3, 8'hFE, -1, 1'b0);
  endtask

  // Payload bytes at both extremes
  task automatic test_payload_extremes();
    send_frame(8'h5A, 8'd5, 8'hA5, 8'h00, 1'b0);
    send_frame(8'hA5, 8'd6, 8'h5A, 8'hFF, 1'b1);
  endtask

  // Random frames with some noise; idling level changes now and then
  task automatic test_random_traffic();
    while (items_sent < RandomItems) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0:       idle_pct <= 0;
          1:       idle_pct <= 10;
          default: idle_pct <= 35;
        endcase
      end
      resync_parser();
      if ($urandom_range(99) < 6) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      else send_random_frame();
    end
  endtask

  // Long output hold-off while requests keep coming
  task automatic test_output_holdoff();
    int unsigned start;
    idle_pct <= 0;
    resync_parser();
    hold_go <= 1'b1;
    start = items_sent;
    while (items_sent - start < 80) send_random_frame();
  endtask

  // Last stretch at full rate on both sides
  task automatic test_full_rate();
    int unsigned start;
    idle_pct <= 0;
    resync_parser();
    start = items_sent;
    while (items_sent - start < 60) send_random_frame();
  endtask

  // Main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_short_frames();
    test_length_errors();
    test_payload_extremes();
    test_random_traffic();
    test_output_holdoff();
    test_full_rate();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_xor_checked_frame_parser: PASS");
    end else begin
      $display("tb_xor_checked_frame_parser: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutNs);
    $display("tb_xor_checked_frame_parser: FAIL");
    $finish;
  end

  // Long hold-off, counted here once armed
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Output stall: hold-off, else random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else if (hold_on) begin
      out_stall <= 1'b1;
    end else if (rx_gap != 0) begin
      out_stall <= 1'b1;
      rx_gap    <= rx_gap - 1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_stall <= 1'b1;
      rx_gap    <= $urandom_range(14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic string show(xcfp_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h idx=%0d dest=%02h size=%0d pid=%02h eof=%0b",
                     r.kind, r.payload_byte, r.payload_index, r.dest_address,
                     r.frame_size, r.payload_kind, r.end_of_frame);
  endfunction

  // Result check against the oldest queued expectation
  always @(posedge clk) begin : check_results
    xcfp_pkg::result_t got;
    xcfp_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.kind          = xcfp_pkg::kind_t'(kind);
      got.payload_byte  = payload_byte;
      got.payload_index = payload_index;
      got.dest_address  = dest_address;
      got.frame_size    = frame_size;
      got.payload_kind  = payload_kind;
      got.end_of_frame  = end_of_frame;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) $display("unexpected result: %s", show(got));
      end else begin
        want = reports_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

endmodule

FILE: files.f
src/xcfp_pkg.sv
src/xcfp_in_reg.sv
src/xcfp_core.sv
src/xcfp_out_reg.sv
src/xor_checked_frame_parser.sv
bench/tb_xor_checked_frame_parser.sv
